// File: rtl/core/scd_pkg.sv
// Shared types, constants and register indexes of the sector cache directory.
`default_nettype none

package scd_pkg;

  localparam int unsigned SCD_ENTRIES     = 64;
  localparam int unsigned SCD_SECTOR_BITS = 32;

  localparam int unsigned SECTOR_W   = 32;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 1'b1;

  localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 7'd64;

  localparam logic OP_LOOKUP  = 1'b0;
  localparam logic OP_INSTALL = 1'b1;

  typedef struct packed {
    logic                op;
    logic [SECTOR_W-1:0] sector;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                present;
    logic                evicted;
    logic [SECTOR_W-1:0] evicted_sector;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/scd_ram.sv
// Single-port directory RAM with a registered read port.
`default_nettype none

module scd_ram #(
  parameter int unsigned DEPTH = scd_pkg::SCD_ENTRIES,
  parameter int unsigned WIDTH = scd_pkg::SCD_SECTOR_BITS + scd_pkg::STAMP_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/scd_search.sv
// Match and least-recently-used search over the words streamed out of the RAM.
`default_nettype none

module scd_search #(
  parameter int unsigned ENTRIES     = scd_pkg::SCD_ENTRIES,
  parameter int unsigned SECTOR_BITS = scd_pkg::SCD_SECTOR_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clear_i,
  input  wire logic                       valid_i,
  input  wire logic [$clog2(ENTRIES)-1:0] idx_i,
  input  wire logic [SECTOR_BITS-1:0]     key_i,
  input  wire logic [SECTOR_BITS-1:0]     sector_i,
  input  wire logic [scd_pkg::STAMP_W-1:0] stamp_i,
  output logic                            found_o,
  output logic      [$clog2(ENTRIES)-1:0] match_idx_o,
  output logic      [$clog2(ENTRIES)-1:0] min_idx_o,
  output logic      [SECTOR_BITS-1:0]     min_sector_o
);

  import scd_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);

  logic                   found_q, found_d;
  logic [IW-1:0]          match_idx_q, match_idx_d;
  logic [IW-1:0]          min_idx_q, min_idx_d;
  logic [STAMP_W-1:0]     min_stamp_q, min_stamp_d;
  logic [SECTOR_BITS-1:0] min_sector_q, min_sector_d;

  always_comb begin
    found_d      = found_q;
    match_idx_d  = match_idx_q;
    min_idx_d    = min_idx_q;
    min_stamp_d  = min_stamp_q;
    min_sector_d = min_sector_q;
    if (clear_i) begin
      found_d = 1'b0;
    end else if (valid_i) begin
      if (!found_q && (sector_i == key_i)) begin
        found_d     = 1'b1;
        match_idx_d = idx_i;
      end
      // The first word seeds the minimum; strict less-than keeps the lowest slot on ties.
      if ((idx_i == '0) || (stamp_i < min_stamp_q)) begin
        min_idx_d    = idx_i;
        min_stamp_d  = stamp_i;
        min_sector_d = sector_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q  <= match_idx_d;
    min_idx_q    <= min_idx_d;
    min_stamp_q  <= min_stamp_d;
    min_sector_q <= min_sector_d;
  end

  assign found_o      = found_q;
  assign match_idx_o  = match_idx_q;
  assign min_idx_o    = min_idx_q;
  assign min_sector_o = min_sector_q;

  a_found_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && !clear_i |=> found_q)
    else $error("match flag dropped during a search");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> !found_q)
    else $error("match flag survived a clear");

  a_match_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q && !clear_i && valid_i && (sector_i == key_i) |=> found_q && (match_idx_q == $past(idx_i)))
    else $error("matching word not recorded");

endmodule

`default_nettype wire

// File: rtl/core/sector_cache_lru_directory.sv
// Top level of the fully associative sector cache directory with LRU replacement.
// Once start is taken, ST_SCAN reads each filled slot in turn, one slot a cycle through the single RAM
// port; ST_WAIT lets the last read reach the search; ST_DECIDE writes any touched slot and forms the result,
// which is registered and strobed. When caching is disabled or the directory is empty, ST_SCAN and ST_WAIT are skipped.
// A new start is taken in the cycle the previous result is strobed; the receiver cannot stall.
// Reset clears the fill count and use counter, enables caching and sets capacity to 64; no clearing pass.
`default_nettype none

module sector_cache_lru_directory #(
  parameter int unsigned ENTRIES     = scd_pkg::SCD_ENTRIES,
  parameter int unsigned SECTOR_BITS = scd_pkg::SCD_SECTOR_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire scd_pkg::req_t                  req_i,
  output logic                                result_valid_o,
  output scd_pkg::rsp_t                       rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [scd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [scd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import scd_pkg::*;

  localparam int unsigned IW     = $clog2(ENTRIES);
  localparam int unsigned CW     = $clog2(ENTRIES + 1);
  localparam int unsigned EW     = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam int unsigned WORD_W = SECTOR_BITS + STAMP_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic                   enable_q;
  logic [CFG_DATA_W-1:0]  cap_q;
  logic                   op_q, op_d;
  logic [SECTOR_BITS-1:0] key_q, key_d;
  logic [IW-1:0]          rd_idx_q, rd_idx_d;
  logic                   rvalid_q;
  logic [IW-1:0]          ridx_q;
  logic [CW-1:0]          count_q, count_d;
  logic [STAMP_W-1:0]     use_q, use_d;
  rsp_t                   rsp_q, rsp_d;
  logic                   rsp_valid_q, rsp_valid_d;

  logic                   accept;
  logic                   last_rd;
  logic                   room;
  logic                   touch;
  logic [IW-1:0]          target;
  logic [EW-1:0]          cap_ext, eff_cap;

  logic                   mem_we, mem_re;
  logic [IW-1:0]          mem_addr;
  logic [WORD_W-1:0]      mem_wdata, mem_rdata;

  logic                   found;
  logic [IW-1:0]          match_idx, min_idx;
  logic [SECTOR_BITS-1:0] min_sector;

  logic [SECTOR_W+SECTOR_BITS-1:0] key_wide, ev_wide;
  logic [SLOT_W+IW-1:0]            slot_wide;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && (state_q == ST_IDLE);

  // Input sectors are widened or cut to the stored width, and back for the result.
  assign key_wide  = (SECTOR_W + SECTOR_BITS)'(req_i.sector);
  assign ev_wide   = (SECTOR_W + SECTOR_BITS)'(min_sector);
  assign slot_wide = (SLOT_W + IW)'(target);

  assign cap_ext = EW'(cap_q);
  assign eff_cap = (cap_q == '0) ? EW'(1) :
                   ((cap_ext > EW'(ENTRIES)) ? EW'(ENTRIES) : cap_ext);
  assign room    = EW'(count_q) < eff_cap;

  assign last_rd = (CW'(rd_idx_q) == (count_q - CW'(1)));

  // Slots fill from zero upward and are never freed, so slot i is valid exactly when i < count.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    rd_idx_d    = rd_idx_q;
    count_d     = count_q;
    use_d       = use_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = rd_idx_q;
    touch       = 1'b0;
    target      = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = req_i.op;
          key_d    = key_wide[SECTOR_BITS-1:0];
          rd_idx_d = '0;
          if (enable_q && (count_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_SCAN: begin
        mem_re = 1'b1;
        if (last_rd) begin
          state_d = ST_WAIT;
        end else begin
          rd_idx_d = rd_idx_q + IW'(1);
        end
      end
      ST_WAIT: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        rsp_d       = '0;
        rsp_valid_d = 1'b1;
        state_d     = ST_IDLE;
        if (enable_q) begin
          if (found) begin
            touch     = 1'b1;
            target    = match_idx;
            rsp_d.hit = 1'b1;
          end else if (op_q == OP_INSTALL) begin
            touch = 1'b1;
            if (room) begin
              target  = count_q[IW-1:0];
              count_d = count_q + CW'(1);
            end else begin
              target               = min_idx;
              rsp_d.evicted        = 1'b1;
              rsp_d.evicted_sector = ev_wide[SECTOR_W-1:0];
            end
          end
        end
        if (touch) begin
          mem_we        = 1'b1;
          mem_addr      = target;
          rsp_d.present = 1'b1;
          rsp_d.slot    = slot_wide[SLOT_W-1:0];
          if (use_q != '1) begin
            use_d = use_q + STAMP_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mem_wdata = {key_q, use_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      use_q       <= '0;
      rvalid_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
      enable_q    <= 1'b1;
      cap_q       <= CAPACITY_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      use_q       <= use_d;
      rvalid_q    <= mem_re;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CACHE_ENABLE: enable_q <= cfg_wdata_i[0];
          REG_CAPACITY:     cap_q    <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    rd_idx_q <= rd_idx_d;
    ridx_q   <= rd_idx_q;
    rsp_q    <= rsp_d;
  end

  scd_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  scd_search #(
    .ENTRIES     (ENTRIES),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (accept),
    .valid_i      (rvalid_q),
    .idx_i        (ridx_q),
    .key_i        (key_q),
    .sector_i     (mem_rdata[WORD_W-1:STAMP_W]),
    .stamp_i      (mem_rdata[STAMP_W-1:0]),
    .found_o      (found),
    .match_idx_o  (match_idx),
    .min_idx_o    (min_idx),
    .min_sector_o (min_sector)
  );

  assign result_valid_o = rsp_valid_q;
  assign rsp_o          = rsp_q;

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobed while a search is running");

  a_decide_strobes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |=> result_valid_o)
    else $error("decision did not produce a result word");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("fill count exceeds the directory depth");

  a_evict_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.evicted |-> rsp_o.present && !rsp_o.hit)
    else $error("eviction reported without an install");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word did not raise busy");

endmodule

`default_nettype wire
